[design/dds_waveform_generator_core_assert.svh]
// assertion macros for the dds waveform generator core
`ifndef DDS_WAVEFORM_GENERATOR_CORE_ASSERT_SVH
`define DDS_WAVEFORM_GENERATOR_CORE_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during reset
`define DWG_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwg assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define DWG_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwg assertion failed");
`else
`define DWG_ASSERT_SAME(lbl, ante, cons)
`define DWG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[design/dwg_pkg.sv]
// shared types, constants and the quarter-wave sine function of the dds core
package dwg_pkg;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_TRIANGLE = 2'd2
    } wave_sel_t;

    typedef enum logic [1:0] {
        REG_WAVE_TYPE  = 2'd0,
        REG_PHASE_STEP = 2'd1,
        REG_AMPLITUDE  = 2'd2,
        REG_DC_OFFSET  = 2'd3
    } cfg_reg_t;

    localparam logic [1:0]         WAVE_TYPE_RST  = 2'd0;
    localparam logic [31:0]        PHASE_STEP_RST = 32'd429496730;
    localparam logic [15:0]        AMPLITUDE_RST  = 16'd1;
    localparam logic signed [15:0] DC_OFFSET_RST  = 16'sd0;

    localparam logic signed [19:0] SAMPLE_MAX = 20'sd32767;
    localparam logic signed [19:0] SAMPLE_MIN = -20'sd32768;

    localparam logic [63:0] HALFPI_Q30 = 64'd1686629713;
    localparam int          TRI_BITS   = 16;

    // round(sin(q / quarter * pi/2) * 2^15) by a q30 taylor series up to x^13
    function automatic logic [15:0] quarter_sine(input int unsigned q,
                                                 input int unsigned addr_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        rnd;
        x    = (64'(q) * HALFPI_Q30) >> (addr_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        acc  = signed'(x);
        term = ((term * x2) >> 30) / 64'd6;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        acc  = acc + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        acc  = acc + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        acc  = acc - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        acc  = acc + signed'(term);
        if (acc < 0)
        begin
            acc = '0;
        end
        rnd = (unsigned'(acc) + 64'd16384) >> 15;
        return rnd[15:0];
    endfunction

endpackage

[design/dds_waveform_generator_core.sv]
// dds waveform generator: phase accumulator, wave shaping, scaling and saturation
// an accepted tick item is registered in stage a, then stage b, then the output sample
// throughput: one item per unstalled cycle, 3 register stages (table, multiply, sum)
// a stall on the output holds all stages; s_tready is low only while the output is held
// reset clears the phase, the stage valid bits and loads the register reset values
`include "dds_waveform_generator_core_assert.svh"

module dds_waveform_generator_core #(
    parameter int PHASE_BITS     = 32,
    parameter int SINE_ADDR_BITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave side: tick items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    input  logic        s_tlast,   // final_tick
    // master side: samples
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample
    output logic [0:0]  m_tuser,   // [0] clipped
    output logic        m_tlast,   // end_of_run
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import dwg_pkg::*;

    localparam int QUARTER = 2 ** (SINE_ADDR_BITS - 2);
    localparam int QB      = SINE_ADDR_BITS - 2;
    localparam logic [15:0] QS_PEAK = quarter_sine(QUARTER, SINE_ADDR_BITS);

    // configuration registers
    logic [1:0]         wave_type_reg;
    logic [31:0]        phase_step_reg;
    logic [15:0]        amplitude_reg;
    logic signed [15:0] dc_offset_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_type_reg  <= WAVE_TYPE_RST;
            phase_step_reg <= PHASE_STEP_RST;
            amplitude_reg  <= AMPLITUDE_RST;
            dc_offset_reg  <= DC_OFFSET_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WAVE_TYPE:  wave_type_reg  <= pwdata[1:0];
                REG_PHASE_STEP: phase_step_reg <= pwdata;
                REG_AMPLITUDE:  amplitude_reg  <= pwdata[15:0];
                REG_DC_OFFSET:  dc_offset_reg  <= signed'(pwdata[15:0]);
                default:        wave_type_reg  <= wave_type_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WAVE_TYPE:  prdata = {30'd0, wave_type_reg};
            REG_PHASE_STEP: prdata = phase_step_reg;
            REG_AMPLITUDE:  prdata = {16'd0, amplitude_reg};
            REG_DC_OFFSET:  prdata = {{16{dc_offset_reg[15]}}, dc_offset_reg};
            default:        prdata = '0;
        endcase
    end

    // quarter-wave sine table, constant
    logic [15:0] qtab [QUARTER];
    for (genvar k = 0; k < QUARTER; k++)
    begin : g_qtab
        assign qtab[k] = quarter_sine(k, SINE_ADDR_BITS);
    end

    // pipeline control
    logic en;
    logic accept;
    logic a_valid_reg, b_valid_reg, out_valid_reg;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // phase accumulator
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] ph;
    logic [PHASE_BITS-1:0] step_ext;
    logic [PHASE_BITS-1:0] phase_acc_next;

    assign ph             = s_tdata[0] ? '0 : phase_acc_reg;
    assign step_ext       = PHASE_BITS'(phase_step_reg);
    assign phase_acc_next = ph + step_ext;

    // stage a: wave operand from the phase
    logic [TRI_BITS-1:0]       u;
    logic [SINE_ADDR_BITS-1:0] addr;
    logic [1:0]                quad;
    logic [QB-1:0]             r;
    logic [QB-1:0]             qidx;
    logic [15:0]               mag;
    logic signed [17:0]        sine_val;
    logic signed [18:0]        tri_wide;
    logic signed [17:0]        a_opnd_next;
    logic                      a_tri_next;

    assign u    = ph[PHASE_BITS-1 -: TRI_BITS];
    assign addr = u[TRI_BITS-1 -: SINE_ADDR_BITS];
    assign quad = addr[SINE_ADDR_BITS-1 -: 2];
    assign r    = addr[QB-1:0];
    // falling quarters read the table mirrored; the mirror of entry zero is the peak
    assign qidx = quad[0] ? (~r) + QB'(1) : r;
    assign mag  = (quad[0] && (r == '0)) ? QS_PEAK : qtab[qidx];
    assign sine_val = quad[1] ? -signed'({2'b00, mag}) : signed'({2'b00, mag});
    assign tri_wide = u[TRI_BITS-1]
                    ? 19'sd196608 - signed'({1'b0, u, 2'b00})
                    : signed'({1'b0, u, 2'b00}) - 19'sd65536;

    always_comb
    begin
        a_tri_next = 1'b0;
        case (wave_type_reg)
            WAVE_SINE:     a_opnd_next = sine_val;
            // square as +-2^15 so the common round-and-shift gives +-amplitude
            WAVE_SQUARE:   a_opnd_next = u[TRI_BITS-1] ? -18'sd32768 : 18'sd32768;
            WAVE_TRIANGLE:
            begin
                a_opnd_next = tri_wide[17:0];
                a_tri_next  = 1'b1;
            end
            default:       a_opnd_next = '0;
        endcase
    end

    logic signed [17:0] a_opnd_reg;
    logic               a_tri_reg;
    logic               a_last_reg;

    // stage b: scale by amplitude
    logic signed [34:0] b_prod_next;
    logic signed [34:0] b_prod_reg;
    logic               b_tri_reg;
    logic               b_last_reg;

    assign b_prod_next = 35'(a_opnd_reg) * 35'(signed'({1'b0, amplitude_reg}));

    // stage c: round, add offset, saturate
    logic signed [34:0] rnd_sum;
    logic signed [34:0] wave_full;
    logic signed [19:0] total;
    logic signed [15:0] sample_next;
    logic               clip_next;

    assign rnd_sum   = b_prod_reg + (b_tri_reg ? 35'sd32768 : 35'sd16384);
    assign wave_full = b_tri_reg ? (rnd_sum >>> 16) : (rnd_sum >>> 15);
    assign total     = 20'(wave_full) + 20'(dc_offset_reg);

    always_comb
    begin
        if (total > SAMPLE_MAX)
        begin
            sample_next = SAMPLE_MAX[15:0];
            clip_next   = 1'b1;
        end
        else if (total < SAMPLE_MIN)
        begin
            sample_next = SAMPLE_MIN[15:0];
            clip_next   = 1'b1;
        end
        else
        begin
            sample_next = total[15:0];
            clip_next   = 1'b0;
        end
    end

    logic signed [15:0] out_sample_reg;
    logic               out_clip_reg;
    logic               out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_acc_reg <= phase_acc_next;
            end
            if (en)
            begin
                a_valid_reg   <= accept;
                b_valid_reg   <= a_valid_reg;
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_opnd_reg     <= a_opnd_next;
            a_tri_reg      <= a_tri_next;
            a_last_reg     <= s_tlast;
            b_prod_reg     <= b_prod_next;
            b_tri_reg      <= a_tri_reg;
            b_last_reg     <= a_last_reg;
            out_sample_reg <= sample_next;
            out_clip_reg   <= clip_next;
            out_last_reg   <= b_last_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_sample_reg;
    assign m_tuser[0] = out_clip_reg;
    assign m_tlast    = out_last_reg;

    `DWG_ASSERT_NEXT(a_restart_phase, accept && s_tdata[0],
        phase_acc_reg == $past(step_ext))
    `DWG_ASSERT_NEXT(a_phase_holds, !accept, $stable(phase_acc_reg))
    `DWG_ASSERT_SAME(a_clip_at_limit, out_valid_reg && out_clip_reg,
        (out_sample_reg == 16'sh7fff) || (out_sample_reg == 16'sh8000))

endmodule

[tb/sv/tb_dds_waveform_generator_core.sv]
`timescale 1ns / 1ps
// self-checking testbench for the dds waveform generator core: ticks in, checked samples out
module tb_dds_waveform_generator_core;
    import dwg_pkg::*;

    localparam int         CYCLE_LIMIT  = 1000000;
    localparam int         LONG_HOLD    = 400;
    localparam int         LUT_DEPTH    = 1024;
    localparam int         LUT_QUARTER  = LUT_DEPTH / 4;
    localparam logic [1:0] WAVE_UNUSED  = 2'd3;

    typedef struct packed {
        logic restart;
        logic final_tick;
    } tick_t;

    typedef struct packed {
        logic [15:0] sample;
        logic        clipped;
        logic        end_of_run;
    } sample_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;   // [0] restart, [7:1] zero
    logic        s_tlast  = 1'b0;   // final_tick
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [15:0] sample
    logic [0:0]  m_tuser;           // [0] clipped
    logic        m_tlast;           // end_of_run
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = 4'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // predictor copy of the registers and the phase
    logic [1:0]         cur_wave;
    logic [31:0]        cur_step;
    logic [15:0]        cur_amp;
    logic signed [15:0] cur_offset;
    logic [31:0]        dds_phase;
    int                 sine_lut [0:LUT_DEPTH-1];

    tick_t   pending_ticks [$];
    sample_t expected_samples [$];
    tick_t   next_tick;
    sample_t want_sample;

    int tick_gap       = 0;
    int hold_left      = 0;
    int long_hold_req  = 0;
    int long_hold_seen = 0;
    bit src_quiet      = 1'b0;
    bit snk_quiet      = 1'b0;
    int src_roll;
    int snk_roll;
    int cycle_count    = 0;
    int errors         = 0;
    int ticks_sent     = 0;
    int samples_seen   = 0;
    int clips_seen     = 0;
    int config_sets    = 0;

    dds_waveform_generator_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // q30 taylor series of sin over one quarter, result in units of 2^-15
    function automatic int quarter_sin(input int unsigned q);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          acc;
        x    = (64'(q) * 64'd1686629713) / 64'(LUT_QUARTER);
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return int'((unsigned'(acc) + 64'd16384) >> 15);
    endfunction

    function automatic sample_t predict_sample(input tick_t t);
        logic [31:0] ph;
        longint      wave;
        longint      u;
        longint      v;
        longint      total;
        sample_t     r;
        if (t.restart)
            dds_phase = '0;
        ph = dds_phase;
        case (cur_wave)
            WAVE_SINE:
                wave = (longint'(sine_lut[ph[31:22]]) * longint'(cur_amp) + 16384) >>> 15;
            WAVE_SQUARE:
                wave = ph[31] ? -longint'(cur_amp) : longint'(cur_amp);
            WAVE_TRIANGLE:
            begin
                u    = longint'(ph[31:16]);
                v    = (u < 32768) ? (4 * u - 65536) : (196608 - 4 * u);
                wave = (v * longint'(cur_amp) + 32768) >>> 16;
            end
            default:
                wave = 0;
        endcase
        total     = wave + longint'(cur_offset);
        r.clipped = 1'b0;
        if (total > SAMPLE_MAX)
        begin
            total     = SAMPLE_MAX;
            r.clipped = 1'b1;
        end
        else if (total < SAMPLE_MIN)
        begin
            total     = SAMPLE_MIN;
            r.clipped = 1'b1;
        end
        r.sample     = 16'(total);
        r.end_of_run = t.final_tick;
        dds_phase    = ph + cur_step;
        return r;
    endfunction

    function automatic int draw_gap();
        if (src_quiet)
            return 0;
        src_roll = $urandom_range(0, 99);
        if (src_roll < 60)
            return 0;
        else if (src_roll < 90)
            return $urandom_range(1, 3);
        else if (src_roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // tick source
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'd0;
            s_tlast  <= 1'b0;
            tick_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (tick_gap != 0)
            begin
                s_tvalid <= 1'b0;
                tick_gap <= tick_gap - 1;
            end
            else if (pending_ticks.size() != 0)
            begin
                next_tick = pending_ticks.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, next_tick.restart};
                s_tlast  <= next_tick.final_tick;
                tick_gap <= draw_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // sample sink with random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (long_hold_req != long_hold_seen)
        begin
            long_hold_seen <= long_hold_req;
            hold_left      <= LONG_HOLD;
            m_tready       <= 1'b0;
        end
        else if (snk_quiet)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            snk_roll = $urandom_range(0, 99);
            if (snk_roll < 70)
            begin
                m_tready <= 1'b1;
            end
            else if (snk_roll < 95)
            begin
                m_tready  <= 1'b0;
                hold_left <= $urandom_range(0, 3);
            end
            else
            begin
                m_tready  <= 1'b0;
                hold_left <= $urandom_range(10, 40);
            end
        end
    end

    // prediction on accepted ticks, comparison on accepted samples
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                expected_samples.push_back(predict_sample({s_tdata[0], s_tlast}));
                ticks_sent++;
            end
            if (m_tvalid && m_tready)
            begin
                samples_seen++;
                if (expected_samples.size() == 0)
                begin
                    $display("%0t: sample %0d arrived with nothing expected",
                             $time, $signed(m_tdata));
                    errors++;
                end
                else
                begin
                    want_sample = expected_samples.pop_front();
                    if (want_sample.clipped)
                        clips_seen++;
                    if (m_tdata !== want_sample.sample)
                    begin
                        $display("%0t: sample expected %0d actual %0d", $time,
                                 $signed(want_sample.sample), $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser[0] !== want_sample.clipped)
                    begin
                        $display("%0t: clipped expected %0b actual %0b", $time,
                                 want_sample.clipped, m_tuser[0]);
                        errors++;
                    end
                    if (m_tlast !== want_sample.end_of_run)
                    begin
                        $display("%0t: end_of_run expected %0b actual %0b", $time,
                                 want_sample.end_of_run, m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d samples still outstanding", $time,
                     expected_samples.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_idle();
        @(negedge clk);
        while (pending_ticks.size() != 0 || s_tvalid || expected_samples.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic apb_write(input cfg_reg_t idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        case (idx)
            REG_WAVE_TYPE:  cur_wave   = val[1:0];
            REG_PHASE_STEP: cur_step   = val;
            REG_AMPLITUDE:  cur_amp    = val[15:0];
            REG_DC_OFFSET:  cur_offset = val[15:0];
        endcase
    endtask

    // upper bits of the wave, amplitude and offset writes are junk that the block must drop
    task automatic set_config(input logic [1:0] wave, input logic [31:0] step,
                              input logic [15:0] amp, input logic [15:0] offset);
        apb_write(REG_WAVE_TYPE, {30'($urandom), wave});
        apb_write(REG_PHASE_STEP, step);
        apb_write(REG_AMPLITUDE, {16'($urandom), amp});
        apb_write(REG_DC_OFFSET, {16'($urandom), offset});
        config_sets++;
    endtask

    task automatic push_tick(input logic restart, input logic final_tick);
        tick_t t;
        t.restart    = restart;
        t.final_tick = final_tick;
        pending_ticks.push_back(t);
    endtask

    // mostly well-formed runs (restart first, final tick last), some noise
    task automatic queue_runs(input int count);
        int  run_len;
        bit  broken;
        while (count > 0)
        begin
            run_len = $urandom_range(1, 24);
            if (run_len > count)
                run_len = count;
            broken = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < run_len; i++)
            begin
                if (broken)
                    push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                else
                    push_tick(i == 0 || $urandom_range(0, 24) == 0,
                              i == run_len - 1 || $urandom_range(0, 24) == 0);
            end
            count -= run_len;
        end
    endtask

    task automatic random_config();
        logic [1:0]  wave;
        logic [31:0] step;
        logic [15:0] amp;
        logic [15:0] offset;
        src_roll = $urandom_range(0, 19);
        wave = (src_roll < 6) ? WAVE_SINE : (src_roll < 12) ? WAVE_SQUARE :
               (src_roll < 18) ? WAVE_TRIANGLE : WAVE_UNUSED;
        case ($urandom_range(0, 7))
            0:       step = 32'd0;
            1:       step = 32'hFFFF_FFFF;
            2:       step = $urandom_range(1, 1 << 20);
            default: step = $urandom;
        endcase
        case ($urandom_range(0, 7))
            0:       amp = 16'd0;
            1:       amp = 16'hFFFF;
            2:       amp = 16'($urandom_range(1, 255));
            default: amp = 16'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       offset = 16'h8000;
            1:       offset = 16'h7FFF;
            2:       offset = 16'h0000;
            default: offset = 16'($urandom);
        endcase
        set_config(wave, step, amp, offset);
    endtask

    initial
    begin
        for (int k = 0; k < LUT_DEPTH; k++)
        begin
            src_roll = (k / LUT_QUARTER) % 2 ? quarter_sin(LUT_QUARTER - k % LUT_QUARTER)
                                             : quarter_sin(k % LUT_QUARTER);
            sine_lut[k] = (k / LUT_QUARTER) >= 2 ? -src_roll : src_roll;
        end
        cur_wave   = WAVE_TYPE_RST;
        cur_step   = PHASE_STEP_RST;
        cur_amp    = AMPLITUDE_RST;
        cur_offset = DC_OFFSET_RST;
        dds_phase  = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values of the registers
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        wait_idle();

        // full-scale sine at the four quadrant points, peak clips
        set_config(WAVE_SINE, 32'h4000_0000, 16'hFFFF, 16'h0000);
        push_tick(1'b1, 1'b0);
        repeat (3) push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        wait_idle();

        set_config(WAVE_SQUARE, 32'h8000_0000, 16'hFFFF, 16'h7FFF);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        wait_idle();

        set_config(WAVE_TRIANGLE, 32'h2000_0000, 16'hFFFF, 16'h8000);
        push_tick(1'b1, 1'b0);
        repeat (3) push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b1);
        wait_idle();

        // unused wave select gives the offset alone
        set_config(WAVE_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 16'h3039);
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        wait_idle();

        set_config(WAVE_SINE, 32'd0, 16'd0, 16'h8000);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        wait_idle();

        for (int p = 0; p < 12; p++)
        begin
            src_quiet = (p == 2 || p == 4 || p == 7);
            snk_quiet = (p == 4);
            random_config();
            if (p == 9)
            begin
                // sender pauses until everything has drained, then resumes
                queue_runs(64);
                wait_idle();
                queue_runs(64);
            end
            else
            begin
                queue_runs(128);
            end
            if (p == 2 || p == 7)
                long_hold_req = long_hold_req + 1;
            wait_idle();
        end
        src_quiet = 1'b0;
        snk_quiet = 1'b0;
        repeat (8) @(negedge clk);

        $display("%0d ticks over %0d register settings, %0d samples compared, %0d clipped",
                 ticks_sent, config_sets, samples_seen, clips_seen);
        $display("all four wave selects, amplitude and offset extremes, restarts and stalls");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/dwg_pkg.sv
design/dds_waveform_generator_core.sv
tb/sv/tb_dds_waveform_generator_core.sv
